>>> hdl/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define BLD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define BLD_NEVER(lbl, clk, rst_n, expr, msg) \
  `BLD_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define BLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BLD_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> hdl/bld_pkg.sv
// Shared types for the linear Diophantine solver.
// Used by bld_divacc and the top level; no dependencies.
package bld_pkg;

  // Request from the sequencer to the divide/accumulate unit
  typedef struct packed {
    logic start;     // begin one division pass
    logic round_up;  // add one more weight when the remainder is nonzero
  } bld_cmd_t;

  // Status back from the divide/accumulate unit
  typedef struct packed {
    logic done;      // one-cycle pulse, results valid until next start
    logic rem_zero;  // final remainder is zero
  } bld_sts_t;

endpackage

>>> hdl/bld_divacc.sv
// Shared iterative unit: restoring divider, one quotient bit per cycle, that
// folds each quotient bit into two Horner accumulators. Depends on bld_pkg.
`include "assert_macros.svh"
module bld_divacc #(
  parameter int unsigned W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bld_pkg::bld_cmd_t      cmd_i,
  input  logic [W-1:0]           dividend_i,
  input  logic [W-1:0]           divisor_i,
  input  logic signed [2*W-1:0]  wx_i,
  input  logic signed [2*W-1:0]  wy_i,
  input  logic signed [2*W-1:0]  bx_i,
  input  logic signed [2*W-1:0]  by_i,
  output bld_pkg::bld_sts_t      sts_o,
  output logic [W-1:0]           rem_o,
  output logic signed [2*W-1:0]  px_o,
  output logic signed [2*W-1:0]  py_o
);

  localparam int unsigned PW   = 2 * W;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

  typedef enum logic [1:0] {U_IDLE, U_DIV, U_CORR, U_BIAS} ustate_e;

  ustate_e               state_q;
  logic [CntW-1:0]       cnt_q;
  logic [W-1:0]          rem_q;
  logic [W-1:0]          dvd_q;
  logic signed [PW-1:0]  px_q;
  logic signed [PW-1:0]  py_q;
  logic                  done_q;

  logic [W:0]            trial;
  logic [W:0]            diff;
  logic                  take;
  logic [W-1:0]          rem_next;
  logic                  round;
  logic signed [PW-1:0]  base_x, base_y, add_x, add_y, sum_x, sum_y;

  // Trial subtract for the next quotient bit
  assign trial    = {rem_q, dvd_q[W-1]};
  assign diff     = trial - {1'b0, divisor_i};
  assign take     = trial >= {1'b0, divisor_i};
  assign rem_next = take ? diff[W-1:0] : trial[W-1:0];
  assign round    = cmd_i.round_up & (rem_q != '0);

  // One adder per lane: double and add while dividing, plain add otherwise
  always_comb begin
    base_x = (state_q == U_DIV) ? (px_q <<< 1) : px_q;
    base_y = (state_q == U_DIV) ? (py_q <<< 1) : py_q;
    case (state_q)
      U_DIV: begin
        add_x = take ? wx_i : '0;
        add_y = take ? wy_i : '0;
      end
      U_CORR: begin
        add_x = round ? wx_i : '0;
        add_y = round ? wy_i : '0;
      end
      U_BIAS: begin
        add_x = bx_i;
        add_y = by_i;
      end
      default: begin
        add_x = '0;
        add_y = '0;
      end
    endcase
    sum_x = base_x + add_x;
    sum_y = base_y + add_y;
  end

  // Sequence one pass: W divide steps, round-up step, bias step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      px_q    <= '0;
      py_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      // pulse done as the bias step completes
      done_q <= (state_q == U_BIAS);
      case (state_q)
        U_IDLE: begin
          if (cmd_i.start) begin
            dvd_q   <= dividend_i;
            rem_q   <= '0;
            px_q    <= '0;
            py_q    <= '0;
            cnt_q   <= '0;
            state_q <= U_DIV;
          end
        end
        U_DIV: begin
          rem_q <= rem_next;
          dvd_q <= dvd_q << 1;
          px_q  <= sum_x;
          py_q  <= sum_y;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= U_CORR;
          end
        end
        U_CORR: begin
          px_q    <= sum_x;
          py_q    <= sum_y;
          state_q <= U_BIAS;
        end
        U_BIAS: begin
          px_q    <= sum_x;
          py_q    <= sum_y;
          state_q <= U_IDLE;
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);
  assign rem_o          = rem_q;
  assign px_o           = px_q;
  assign py_o           = py_q;

  // Checks
  `BLD_ASSERT(a_start_idle, clk_i, rst_ni, cmd_i.start |-> state_q == U_IDLE,
              "divacc started while busy")
  `BLD_ASSERT(a_rem_below, clk_i, rst_ni, state_q == U_CORR |-> rem_q < divisor_i,
              "remainder not below divisor")
  `BLD_ASSERT(a_pass_len, clk_i, rst_ni,
              state_q == U_CORR |-> $past(state_q, W + 1) == U_IDLE,
              "divide pass length wrong")

endmodule

>>> hdl/bezout_linear_diophantine_solver.sv
// Linear Diophantine solver m*x + n*y = target; sequencer, Euclid registers.
// Zero target or both coefficients zero skip the divide unit and go straight to emit;
// otherwise each Euclid step and the final scaling run one pass of the divide/accumulate
// unit, which produces one quotient bit per cycle.
// Takes one request at a time; the next is taken once a result is registered.
// Reset clears all state; no clearing pass.
`include "assert_macros.svh"
module bezout_linear_diophantine_solver #(
  parameter int unsigned IN_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [IN_WIDTH-1:0]   coef_m_i,
  input  logic signed [IN_WIDTH-1:0]   coef_n_i,
  input  logic signed [IN_WIDTH-1:0]   target_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [2*IN_WIDTH-1:0] sol_x_o,
  output logic signed [2*IN_WIDTH-1:0] sol_y_o,
  output logic                         solvable_o
);

  localparam int unsigned W  = IN_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = W + 2;

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_STEPW, S_FIN, S_FINW, S_EMIT} state_e;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    logic [W-1:0] vu;
    vu = v;
    return vu[W-1] ? (~vu + 1'b1) : vu;
  endfunction

  function automatic logic signed [PW-1:0] sext(input logic signed [CW-1:0] v);
    return {{(PW - CW){v[CW-1]}}, v};
  endfunction

  state_e                state_q;
  logic signed [W-1:0]   a_q, b_q, t_q;
  logic signed [CW-1:0]  x_q, y_q, u_q, v_q;
  logic                  fast_q, fast_ok_q;
  logic                  out_valid_q;
  logic signed [PW-1:0]  sol_x_q, sol_y_q;
  logic                  solvable_q;

  logic                  in_acc, fin, kneg, rneg, emit_go;
  logic [W-1:0]          mag_a, mag_b, mag_t, dividend, divisor, r_val, unit_rem;
  logic signed [PW-1:0]  x_ext, y_ext, u_ext, v_ext, wx, wy, bx, by, px, py;
  bld_pkg::bld_cmd_t     cmd;
  bld_pkg::bld_sts_t     sts;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Operand select: Euclid step divides a by b, final pass divides t by g
  assign fin      = (state_q == S_FIN) || (state_q == S_FINW);
  assign mag_a    = mag(a_q);
  assign mag_b    = mag(b_q);
  assign mag_t    = mag(t_q);
  assign dividend = fin ? mag_t : mag_a;
  assign divisor  = fin ? mag_a : mag_b;

  // Lane weights: -k*u in a step, ratio*x in the final pass
  assign x_ext = sext(x_q);
  assign y_ext = sext(y_q);
  assign u_ext = sext(u_q);
  assign v_ext = sext(v_q);
  assign kneg  = a_q[W-1] ^ b_q[W-1];
  assign rneg  = t_q[W-1] ^ a_q[W-1];
  assign wx    = fin ? (rneg ? -x_ext : x_ext) : (kneg ? u_ext : -u_ext);
  assign wy    = fin ? (rneg ? -y_ext : y_ext) : (kneg ? v_ext : -v_ext);
  assign bx    = fin ? '0 : x_ext;
  assign by    = fin ? '0 : y_ext;

  assign cmd.start    = (state_q == S_STEP) || (state_q == S_FIN);
  assign cmd.round_up = ~fin & a_q[W-1];

  // Nonnegative remainder of a modulo |b|
  assign r_val = (a_q[W-1] && !sts.rem_zero) ? (mag_b - unit_rem) : unit_rem;

  assign emit_go = ~out_valid_q | ~out_stall_i;

  bld_divacc #(
    .W (W)
  ) u_divacc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .wx_i       (wx),
    .wy_i       (wy),
    .bx_i       (bx),
    .by_i       (by),
    .sts_o      (sts),
    .rem_o      (unit_rem),
    .px_o       (px),
    .py_o       (py)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      t_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      u_q         <= '0;
      v_q         <= '0;
      fast_q      <= 1'b0;
      fast_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sol_x_q     <= '0;
      sol_y_q     <= '0;
      solvable_q  <= 1'b0;
    end else begin
      // raise valid on emit, hold it while stalled, drop it once taken
      out_valid_q <= ((state_q == S_EMIT) && emit_go) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            t_q <= target_value_i;
            if (target_value_i == '0) begin
              fast_q    <= 1'b1;
              fast_ok_q <= 1'b1;
              state_q   <= S_EMIT;
            end else if (coef_m_i == '0 && coef_n_i == '0) begin
              fast_q    <= 1'b1;
              fast_ok_q <= 1'b0;
              state_q   <= S_EMIT;
            end else if (coef_m_i == '0) begin
              fast_q  <= 1'b0;
              a_q     <= coef_n_i;
              x_q     <= '0;
              y_q     <= CW'(1);
              state_q <= S_FIN;
            end else if (coef_n_i == '0) begin
              fast_q  <= 1'b0;
              a_q     <= coef_m_i;
              x_q     <= CW'(1);
              y_q     <= '0;
              state_q <= S_FIN;
            end else begin
              fast_q  <= 1'b0;
              a_q     <= coef_m_i;
              b_q     <= coef_n_i;
              x_q     <= CW'(1);
              y_q     <= '0;
              u_q     <= '0;
              v_q     <= CW'(1);
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state_q <= S_STEPW;
        end
        S_STEPW: begin
          if (sts.done) begin
            a_q     <= b_q;
            b_q     <= signed'(r_val);
            x_q     <= u_q;
            y_q     <= v_q;
            u_q     <= px[CW-1:0];
            v_q     <= py[CW-1:0];
            state_q <= (r_val == '0) ? S_FIN : S_STEP;
          end
        end
        S_FIN: begin
          state_q <= S_FINW;
        end
        S_FINW: begin
          if (sts.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            sol_x_q     <= (fast_q || !sts.rem_zero) ? '0 : px;
            sol_y_q     <= (fast_q || !sts.rem_zero) ? '0 : py;
            solvable_q  <= fast_q ? fast_ok_q : sts.rem_zero;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sol_x_o     = sol_x_q;
  assign sol_y_o     = sol_y_q;
  assign solvable_o  = solvable_q;

  // Checks
  `BLD_ASSERT(a_div_nonzero, clk_i, rst_ni, cmd.start |-> divisor != '0,
              "division started with zero divisor")
  `BLD_ASSERT(a_done_wait, clk_i, rst_ni,
              sts.done |-> (state_q == S_STEPW || state_q == S_FINW),
              "unit done outside a wait state")
  `BLD_ASSERT(a_acc_busy, clk_i, rst_ni, in_acc |=> state_q != S_IDLE,
              "accepted request left block idle")

endmodule
